### rtl/core/sfhr_pkg.sv
// Shared types, constants and tables of the heat-map frame receiver.
package sfhr_pkg;

  localparam int LEVEL_W   = 4;
  localparam int COLOR_W   = 16;
  localparam int PERCENT_W = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

  // Response type codes.
  localparam logic RESP_FRAME = 1'b0;
  localparam logic RESP_PIXEL = 1'b1;

  // Request type codes.
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  // Fields of a frame report taken from the status byte.
  typedef struct packed {
    logic [2:0]           batt_code;
    logic [PERCENT_W-1:0] batt_percent;
    logic [1:0]           right_move;
    logic [1:0]           left_move;
  } sfhr_report_t;

  // Control from the link receiver to the rest of the block.
  typedef struct packed {
    logic wr_en;        // payload byte goes into the back bank
    logic front_bank;   // bank that holds the displayed grid
    logic loaded;       // a frame has been completed since reset
    logic report_valid; // status byte closes a frame in this transfer
  } sfhr_link_ctl_t;

  // What travels with an item from the read stage to the output register.
  typedef struct packed {
    logic         resp_type;
    logic         nib_lo;
    logic         loaded;
    sfhr_report_t report;
  } sfhr_stage_t;

  // Sixteen-entry RGB565 palette, cold to hot.
  function automatic logic [COLOR_W-1:0] palette_color(input logic [LEVEL_W-1:0] lvl);
    logic [COLOR_W-1:0] c;
    case (lvl)
      4'd0:    c = 16'h001F;
      4'd1:    c = 16'h101F;
      4'd2:    c = 16'h401F;
      4'd3:    c = 16'h781F;
      4'd4:    c = 16'hF81F;
      4'd5:    c = 16'hF801;
      4'd6:    c = 16'hF800;
      4'd7:    c = 16'hFC00;
      4'd8:    c = 16'hFE00;
      4'd9:    c = 16'hFF00;
      4'd10:   c = 16'hFFE0;
      4'd11:   c = 16'hFFF0;
      default: c = 16'hFFFF;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/sfhr_ifs.sv
// Valid/ready channel interfaces for requests and results.
interface sfhr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic [5:0] pix_x;
  logic [5:0] pix_y;

  modport source (output valid, output req_type, output rx_byte, output pix_x,
                  output pix_y, input ready);
  modport sink (input valid, input req_type, input rx_byte, input pix_x,
                input pix_y, output ready);
endinterface

interface sfhr_out_if;
  import sfhr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 resp_type;
  logic [COLOR_W-1:0]   pixel_color;
  logic [2:0]           batt_code;
  logic [PERCENT_W-1:0] batt_percent;
  logic [1:0]           right_move;
  logic [1:0]           left_move;

  modport source (output valid, output resp_type, output pixel_color, output batt_code,
                  output batt_percent, output right_move, output left_move,
                  input ready);
  modport sink (input valid, input resp_type, input pixel_color, input batt_code,
                input batt_percent, input right_move, input left_move,
                output ready);
endinterface

### rtl/core/sfhr_link_rx.sv
// Link byte receiver: sync hunt, payload count, bank swap and status report.
module sfhr_link_rx #(
  parameter int PAYLOAD_BYTES = 32,
  parameter int ADDR_W        = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               byte_fire,
  input  logic [7:0]                         rx_byte,
  input  logic                               cfg_we,
  input  logic [sfhr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfhr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output sfhr_pkg::sfhr_link_ctl_t           ctl,
  output logic [ADDR_W:0]                    wr_addr,
  output logic [7:0]                         wr_data,
  output sfhr_pkg::sfhr_report_t             report
);
  import sfhr_pkg::*;

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_SYNC2  = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_STATUS = 2'd3;

  localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(PAYLOAD_BYTES - 1);

  logic [7:0]        sync_first_r;
  logic [7:0]        sync_second_r;
  logic [1:0]        phase_r, phase_nxt;
  logic [ADDR_W-1:0] count_r, count_nxt;
  logic              front_r, front_nxt;
  logic              loaded_r, loaded_nxt;
  logic              wr_en;
  logic              report_valid;
  logic [2:0]        code;

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    loaded_nxt   = loaded_r;
    wr_en        = 1'b0;
    report_valid = 1'b0;
    if (byte_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (rx_byte == sync_first_r) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          // A wrong second byte is not retried as a first sync byte.
          if (rx_byte == sync_second_r) begin
            count_nxt = '0;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          wr_en = 1'b1;
          if (count_r == LAST_BYTE) begin
            count_nxt = '0;
            phase_nxt = PH_STATUS;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        default: begin
          // Status byte: the freshly filled back bank becomes the grid.
          report_valid = 1'b1;
          front_nxt    = ~front_r;
          loaded_nxt   = 1'b1;
          phase_nxt    = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      phase_r       <= PH_HUNT;
      count_r       <= '0;
      front_r       <= 1'b0;
      loaded_r      <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      front_r  <= front_nxt;
      loaded_r <= loaded_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
          REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign code = rx_byte[6:4];

  always_comb begin
    report.batt_code  = code;
    report.right_move = rx_byte[3:2];
    report.left_move  = rx_byte[1:0];
    case (code)
      3'd0:    report.batt_percent = 7'd0;
      3'd1:    report.batt_percent = 7'd20;
      3'd2:    report.batt_percent = 7'd40;
      3'd3:    report.batt_percent = 7'd60;
      3'd4:    report.batt_percent = 7'd80;
      3'd5:    report.batt_percent = 7'd100;
      default: report.batt_percent = 7'd0;
    endcase
  end

  assign ctl.wr_en        = wr_en;
  assign ctl.front_bank   = front_r;
  assign ctl.loaded       = loaded_r;
  assign ctl.report_valid = report_valid;
  assign wr_addr          = {~front_r, count_r};
  assign wr_data          = rx_byte;

endmodule

### rtl/core/sfhr_grid_mem.sv
// Two-bank payload memory: one bank is filled while the other is displayed.
module sfhr_grid_mem #(
  parameter int ADDR_W = 5
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [ADDR_W:0] wr_addr,
  input  logic [7:0]      wr_data,
  input  logic            rd_en,
  input  logic [ADDR_W:0] rd_addr,
  output logic [7:0]      rd_data_r
);

  localparam int DEPTH = 2 ** (ADDR_W + 1);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data is held while the stage behind it is stalled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/sfhr_pix_map.sv
// Maps a raster coordinate to the payload byte and nibble of its grid cell.
module sfhr_pix_map #(
  parameter int GRID_SIDE    = 8,
  parameter int CELL_SIZE_PX = 8,
  parameter int ADDR_W       = 5
) (
  input  logic [5:0]        pix_x,
  input  logic [5:0]        pix_y,
  output logic [ADDR_W-1:0] byte_addr,
  output logic              nib_lo
);

  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
  localparam int GW         = $clog2(GRID_SIDE);
  localparam int CW         = $clog2(CELL_COUNT);
  localparam logic [5:0]    LAST_Q  = 6'(GRID_SIDE - 1);

  logic [5:0]    gx_q, gy_q;
  logic [GW-1:0] gx, gy;
  logic [CW-1:0] cell_idx;

  // Quotient of a coordinate by the cell size, taken as a row of compares
  // against the constant multiples of the cell size.
  function automatic logic [5:0] coarse_index(input logic [5:0] coord);
    logic [5:0] q;
    q = '0;
    for (int k = 1; k < 64; k++) begin
      if (int'(coord) >= k * CELL_SIZE_PX) begin
        q = 6'(k);
      end
    end
    return q;
  endfunction

  assign gx_q = coarse_index(pix_x);
  assign gy_q = coarse_index(pix_y);

  // Coordinates beyond the grid land in the last column or row.
  assign gx = (gx_q > LAST_Q) ? GW'(GRID_SIDE - 1) : gx_q[GW-1:0];
  assign gy = (gy_q > LAST_Q) ? GW'(GRID_SIDE - 1) : gy_q[GW-1:0];

  assign cell_idx  = CW'(32'(gy) * GRID_SIDE + 32'(gx));
  assign byte_addr = ADDR_W'(cell_idx >> 1);
  assign nib_lo    = cell_idx[0];

endmodule

### rtl/core/sfhr_out_pipe.sv
// Read stage and output register with valid/ready flow control.
module sfhr_out_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  sfhr_pkg::sfhr_stage_t load_info,
  input  logic [7:0]            rd_data,
  output logic                  can_load,
  sfhr_out_if.source            out_if
);
  import sfhr_pkg::*;

  logic                 s1_valid_r, s1_valid_nxt;
  sfhr_stage_t          s1_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 s1_go;
  logic [LEVEL_W-1:0]   level;
  logic                 resp_type_r;
  logic [COLOR_W-1:0]   color_r;
  sfhr_report_t         report_r;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_if.ready);
  assign can_load = !s1_valid_r || s1_go;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Before the first frame the grid reads as all level zero.
  always_comb begin
    if (!s1_r.loaded) begin
      level = '0;
    end else if (s1_r.nib_lo) begin
      level = rd_data[3:0];
    end else begin
      level = rd_data[7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= load_info;
    end
    if (s1_go) begin
      resp_type_r <= s1_r.resp_type;
      if (s1_r.resp_type == RESP_PIXEL) begin
        color_r  <= palette_color(level);
        report_r <= '0;
      end else begin
        color_r  <= '0;
        report_r <= s1_r.report;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.resp_type    = resp_type_r;
  assign out_if.pixel_color  = color_r;
  assign out_if.batt_code    = report_r.batt_code;
  assign out_if.batt_percent = report_r.batt_percent;
  assign out_if.right_move   = report_r.right_move;
  assign out_if.left_move    = report_r.left_move;

endmodule

### rtl/core/sync_framed_heatmap_receiver_top.sv
// Top level of the sync-framed heat-map receiver.
//
//   Channel  Direction  Carries
//   in_if    sink       link byte (req_type 0) or pixel request (req_type 1)
//   out_if   source     frame report (resp_type 0) or RGB565 pixel answer (1)
//   cfg_*    write      sync_first (index 0) and sync_second (index 1)
//
// A transfer is accepted every cycle while the result side keeps taking
// results; every result passes through the registered payload memory read
// and then through the output register.
// Reset clears the frame state, restores the sync bytes to 0xAA and 0x55 and
// makes the grid read as all level zero; the memory itself is not cleared.
// When out_if is stalled, the read stage and output register fill and then
// in_if.ready drops; link bytes that complete nothing still need a free read stage.
//
// The payload lives in two banks. Link bytes fill the back bank while pixel
// requests read the front bank; the status byte swaps the banks in the same
// cycle, so the next pixel request already sees the new frame. This replaces
// the copy of the payload into the level grid with a single pointer flip.
module sync_framed_heatmap_receiver_top #(
  parameter int GRID_SIDE    = 8,
  parameter int CELL_SIZE_PX = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  sfhr_in_if.sink                         in_if,
  sfhr_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [sfhr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfhr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sfhr_pkg::*;

  localparam int CELL_COUNT    = GRID_SIDE * GRID_SIDE;
  localparam int PAYLOAD_BYTES = (CELL_COUNT + 1) / 2;
  localparam int ADDR_W        = $clog2(PAYLOAD_BYTES);

  logic              in_fire;
  logic              byte_fire;
  logic              load;
  logic              can_load;
  sfhr_link_ctl_t    ctl;
  sfhr_report_t      report;
  sfhr_stage_t       load_info;
  logic [ADDR_W:0]   wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] pix_addr;
  logic              nib_lo;
  logic [7:0]        rd_data;

  assign in_if.ready = can_load;
  assign in_fire     = in_if.valid && can_load;
  assign byte_fire   = in_fire && (in_if.req_type == REQ_BYTE);

  // Only pixel requests and completed frames occupy the read stage.
  assign load = in_fire && ((in_if.req_type == REQ_PIXEL) || ctl.report_valid);

  assign load_info.resp_type = (in_if.req_type == REQ_PIXEL) ? RESP_PIXEL : RESP_FRAME;
  assign load_info.nib_lo    = nib_lo;
  assign load_info.loaded    = ctl.loaded;
  assign load_info.report    = report;

  sfhr_link_rx #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .ADDR_W        (ADDR_W)
  ) u_link_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .rx_byte   (in_if.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .report    (report)
  );

  sfhr_pix_map #(
    .GRID_SIDE    (GRID_SIDE),
    .CELL_SIZE_PX (CELL_SIZE_PX),
    .ADDR_W       (ADDR_W)
  ) u_pix_map (
    .pix_x     (in_if.pix_x),
    .pix_y     (in_if.pix_y),
    .byte_addr (pix_addr),
    .nib_lo    (nib_lo)
  );

  sfhr_grid_mem #(
    .ADDR_W (ADDR_W)
  ) u_grid_mem (
    .clk       (clk),
    .wr_en     (ctl.wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (load),
    .rd_addr   ({ctl.front_bank, pix_addr}),
    .rd_data_r (rd_data)
  );

  sfhr_out_pipe u_out_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_info (load_info),
    .rd_data   (rd_data),
    .can_load  (can_load),
    .out_if    (out_if)
  );

endmodule
